// File: hw/rtl/pvm_pkg.sv
// Shared constants, types and command codes of the PCM voice mixer.
package pvm_pkg;
	localparam int NUM_VOICES       = 16;
	localparam int NUM_SOUNDS       = 16;
	localparam int SAMPLE_MEM_DEPTH = 65536;
	localparam int VW  = $clog2(NUM_VOICES);
	localparam int SW  = 4;
	localparam int AW  = $clog2(SAMPLE_MEM_DEPTH);
	localparam int LW  = 17;
	localparam int FLW = 10;
	localparam int ACCW = 16 + VW + 1;

	localparam logic [2:0] OP_TICK    = 3'd0;
	localparam logic [2:0] OP_PLAY    = 3'd1;
	localparam logic [2:0] OP_STOP    = 3'd2;
	localparam logic [2:0] OP_RELEASE = 3'd3;
	localparam logic [2:0] OP_WRITE   = 3'd4;
	localparam logic [2:0] OP_DEFINE  = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BUSY = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic tick_begin;   // latch frame flags, clear accumulator
		logic voice_step;   // issue memory read for voice in voice_idx
		logic voice_acc;    // accumulate read data of previous voice
		logic tick_end;     // frame bookkeeping and frees
		logic do_cmd;       // execute a non-tick command
		logic [VW-1:0] voice_idx;
		logic acc_valid;
		logic [VW-1:0] acc_idx;
	} pvm_cmd_t;

	typedef struct packed {
		logic mid_frame;
	} pvm_stat_t;
endpackage

// File: hw/rtl/pvm_ram.sv
// Generic single-port-write RAM with a registered read.
module pvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/pvm_datapath.sv
// Voice state, sound tables, sample memory and the mixing accumulator.
module pvm_datapath import pvm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pvm_cmd_t               cmd,
	output pvm_stat_t              stat,
	input  logic [FLW-1:0]         frame_length,
	input  logic [2:0]             opcode,
	input  logic [3:0]             sound_id,
	input  logic [15:0]            sample_address,
	input  logic signed [15:0]     sample_value,
	input  logic [15:0]            sound_start,
	input  logic [16:0]            sound_length,
	output logic signed [15:0]     mix_out,
	output logic                   last_out,
	output logic [1:0]             status_out
);
	logic [NUM_VOICES-1:0] active_q, ending_q;
	logic [SW-1:0]  vsound_q [NUM_VOICES];
	logic [LW-1:0]  vpos_q   [NUM_VOICES];
	logic [15:0]    sstart_q [NUM_SOUNDS];
	logic [LW-1:0]  slen_q   [NUM_SOUNDS];
	logic [FLW-1:0] fidx_q;
	logic signed [ACCW-1:0] acc_q;
	logic first_q, last_q;

	logic [FLW-1:0] len_eff;
	logic [FLW:0]   fnext;
	assign len_eff = (frame_length == '0) ? FLW'(1) : frame_length;
	assign fnext   = {1'b0, fidx_q} + (FLW+1)'(1);
	assign stat.mid_frame = (fidx_q != '0);

	// Per-voice view for the voice being issued.
	logic [SW-1:0] cur_snd;
	logic [LW-1:0] cur_pos, cur_len, cur_left;
	logic          cur_has;
	assign cur_snd  = vsound_q[cmd.voice_idx];
	assign cur_pos  = vpos_q[cmd.voice_idx];
	assign cur_len  = slen_q[cur_snd];
	assign cur_has  = active_q[cmd.voice_idx] && (cur_pos < cur_len);
	assign cur_left = (cur_pos < cur_len) ? cur_len - cur_pos : '0;

	logic [AW-1:0] raddr;
	logic signed [15:0] rdata;
	logic acc_en_q;
	assign raddr = AW'({1'b0, sstart_q[cur_snd]} + cur_pos);

	pvm_ram #(.WIDTH(16), .DEPTH(SAMPLE_MEM_DEPTH)) u_mem (
		.clk  (clk),
		.we   (cmd.do_cmd && !stat.mid_frame && opcode == OP_WRITE),
		.waddr(AW'(sample_address)),
		.wdata(sample_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	// First free voice.
	logic          free_found;
	logic [VW-1:0] free_idx;
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int v = NUM_VOICES - 1; v >= 0; v--) begin
			if (!active_q[v]) begin
				free_found = 1'b1;
				free_idx   = VW'(v);
			end
		end
	end

	logic sid_ok;
	assign sid_ok = ({28'd0, sound_id} < 32'(NUM_SOUNDS));

	always_ff @(posedge clk) begin
		if (cmd.do_cmd && !stat.mid_frame && opcode == OP_DEFINE && sid_ok)
			sstart_q[SW'(sound_id)] <= sound_start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			ending_q <= '0;
			fidx_q   <= '0;
			acc_q    <= '0;
			first_q  <= 1'b0;
			last_q   <= 1'b0;
			acc_en_q <= 1'b0;
			status_out <= ST_OK;
			for (int v = 0; v < NUM_VOICES; v++) begin
				vsound_q[v] <= '0;
				vpos_q[v]   <= '0;
			end
			for (int s = 0; s < NUM_SOUNDS; s++) slen_q[s] <= '0;
		end else begin
			acc_en_q <= cmd.voice_step && cur_has;
			if (cmd.tick_begin) begin
				acc_q   <= '0;
				first_q <= (fidx_q == '0);
				last_q  <= (fnext >= {1'b0, len_eff});
				status_out <= ST_OK;
			end
			if (cmd.voice_step) begin
				if (first_q && active_q[cmd.voice_idx] && cur_left < LW'(len_eff))
					ending_q[cmd.voice_idx] <= 1'b1;
				if (cur_has) vpos_q[cmd.voice_idx] <= cur_pos + LW'(1);
			end
			if (cmd.voice_acc && acc_en_q)
				acc_q <= acc_q + ACCW'(rdata);
			if (cmd.tick_end) begin
				if (last_q) begin
					fidx_q <= '0;
					for (int v = 0; v < NUM_VOICES; v++) begin
						if (active_q[v] && ending_q[v]) begin
							active_q[v] <= 1'b0;
							ending_q[v] <= 1'b0;
							vpos_q[v]   <= '0;
						end
					end
				end else begin
					fidx_q <= fnext[FLW-1:0];
				end
			end
			if (cmd.do_cmd) begin
				status_out <= ST_OK;
				if (stat.mid_frame) begin
					if (opcode >= OP_PLAY && opcode <= OP_DEFINE) status_out <= ST_BUSY;
				end else begin
					unique case (opcode)
						OP_PLAY: if (sid_ok) begin
							if (free_found) begin
								active_q[free_idx] <= 1'b1;
								vsound_q[free_idx] <= SW'(sound_id);
								vpos_q[free_idx]   <= '0;
								ending_q[free_idx] <= 1'b0;
							end else status_out <= ST_FULL;
						end
						OP_STOP: begin
							active_q <= '0;
							ending_q <= '0;
							for (int v = 0; v < NUM_VOICES; v++) vpos_q[v] <= '0;
						end
						OP_RELEASE: if (sid_ok) begin
							for (int v = 0; v < NUM_VOICES; v++) begin
								if (active_q[v] && vsound_q[v] == SW'(sound_id)) begin
									active_q[v] <= 1'b0;
									ending_q[v] <= 1'b0;
									vpos_q[v]   <= '0;
								end
							end
						end
						OP_DEFINE: if (sid_ok) slen_q[SW'(sound_id)] <= sound_length;
						default: ;
					endcase
				end
			end
		end
	end

	always_comb begin
		if (acc_q > ACCW'(32767)) mix_out = 16'sh7FFF;
		else if (acc_q < -ACCW'(32768)) mix_out = -16'sh8000;
		else mix_out = acc_q[15:0];
	end
	assign last_out = last_q;
endmodule

// File: hw/rtl/pvm_ctrl.sv
// Controller that sequences one command or a tick across all voices.
module pvm_ctrl import pvm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic [2:0] opcode,
	input  pvm_stat_t stat,
	output pvm_cmd_t  cmd,
	output logic      busy,
	output logic      done,
	output logic      is_tick
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CMD  = 5'b00010,
		S_RUN  = 5'b00100,
		S_END  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic [VW:0] cnt_q;
	logic [2:0]  op_q;
	logic        acc_pend_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.voice_idx = cnt_q[VW-1:0];
		cmd.tick_begin = (state_q == S_IDLE) && start && opcode == OP_TICK;
		cmd.voice_step = (state_q == S_RUN) && (cnt_q < (VW+1)'(NUM_VOICES));
		cmd.voice_acc  = acc_pend_q;
		cmd.acc_valid  = acc_pend_q;
		cmd.acc_idx    = '0;
		cmd.tick_end   = (state_q == S_END);
		cmd.do_cmd     = (state_q == S_CMD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			op_q    <= OP_TICK;
			acc_pend_q <= 1'b0;
			done    <= 1'b0;
			is_tick <= 1'b0;
		end else begin
			done <= 1'b0;
			acc_pend_q <= cmd.voice_step;
			unique case (state_q)
				S_IDLE: if (start) begin
					op_q  <= opcode;
					cnt_q <= '0;
					state_q <= (opcode == OP_TICK) ? S_RUN : S_CMD;
				end
				S_CMD: begin
					is_tick <= 1'b0;
					state_q <= S_OUT;
				end
				S_RUN: begin
					if (cnt_q < (VW+1)'(NUM_VOICES)) cnt_q <= cnt_q + (VW+1)'(1);
					else if (!acc_pend_q) state_q <= S_END;
				end
				S_END: begin
					is_tick <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
	logic unused_stat;
	assign unused_stat = stat.mid_frame & ^op_q;
endmodule

// File: hw/rtl/pcm_voice_mixer.sv
// Top level of the PCM voice mixer: APB register, controller and datapath.
// A tick runs the voices in S_RUN, one voice per cycle through the single sample memory
// read port, then passes S_END and S_OUT to the result strobe. Other commands pass S_CMD
// and S_OUT. busy is high from acceptance until the strobe, and the next item can be
// accepted in the strobe cycle. The receiver cannot stall.
// Asynchronous reset frees all voices, clears the frame count and length
// table, and sets frame_length to 735; memory contents are undefined.
module pcm_voice_mixer import pvm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         opcode,
	input  logic [3:0]         sound_id,
	input  logic [15:0]        sample_address,
	input  logic signed [15:0] sample_value,
	input  logic [15:0]        sound_start,
	input  logic [16:0]        sound_length,
	output logic               result_valid,
	output logic signed [15:0] mixed_sample,
	output logic               frame_end,
	output logic [1:0]         status
);
	logic [FLW-1:0] frame_length_q;
	pvm_cmd_t  cmd;
	pvm_stat_t stat;
	logic done, is_tick, last_w;
	logic signed [15:0] mix_w;
	logic [1:0] st_w;

	// The command beat is held here, since the datapath executes it after acceptance.
	logic [2:0]         opcode_q;
	logic [3:0]         sound_id_q;
	logic [15:0]        sample_address_q;
	logic signed [15:0] sample_value_q;
	logic [15:0]        sound_start_q;
	logic [16:0]        sound_length_q;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {22'd0, frame_length_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) frame_length_q <= FLW'(735);
		else if (psel && penable && pwrite && paddr == 2'd0)
			frame_length_q <= pwdata[FLW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opcode_q         <= OP_TICK;
			sound_id_q       <= '0;
			sample_address_q <= '0;
			sample_value_q   <= '0;
			sound_start_q    <= '0;
			sound_length_q   <= '0;
		end else if (start && !busy) begin
			opcode_q         <= opcode;
			sound_id_q       <= sound_id;
			sample_address_q <= sample_address;
			sample_value_q   <= sample_value;
			sound_start_q    <= sound_start;
			sound_length_q   <= sound_length;
		end
	end

	pvm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .opcode(opcode),
		.stat(stat), .cmd(cmd), .busy(busy), .done(done), .is_tick(is_tick)
	);

	pvm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.frame_length(frame_length_q), .opcode(opcode_q), .sound_id(sound_id_q),
		.sample_address(sample_address_q), .sample_value(sample_value_q),
		.sound_start(sound_start_q), .sound_length(sound_length_q),
		.mix_out(mix_w), .last_out(last_w), .status_out(st_w)
	);

	assign result_valid = done;
	assign mixed_sample = is_tick ? mix_w : 16'sd0;
	assign frame_end    = is_tick & last_w;
	assign status       = is_tick ? ST_OK : st_w;
endmodule
